>>> design/brq_pkg.sv
// Package for the circular byte queue: sizes, request and result types.
package brq_pkg;

    localparam int QUEUE_BYTES = 1024;
    localparam int MAX_POP     = 64;
    localparam int PTR_W       = $clog2(QUEUE_BYTES);
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 10;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic KIND_PUSH_REPORT = 1'b0;
    localparam logic KIND_POP_RESULT  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [7:0]       push_byte;
        logic             push_run_end;
        logic [LEN_W-1:0] pop_length;
    } t_req;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic [CNT_W-1:0] moved_count;
        logic             run_last;
        logic [CNT_W-1:0] free_bytes;
    } t_rsp;

endpackage

>>> design/brq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module brq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/byte_ring_queue_bulk_core.sv
// Circular byte queue core: push runs with count report, bulk pop from one RAM.
//
//   channel   signals                 direction  handshake
//   request   start, busy, i_req      in         accepted when start & !busy
//   result    o_strobe, o_rsp         out        one strobe per result, no stall
//
// A push never raises busy, so pushes can follow each other. A pop of n
// bytes reads one byte per cycle through the RAM read port and holds busy
// until its last byte is read; each result appears in the cycle after its read.
// An empty pop answers in the next cycle. Reset clears pointers and run count;
// the byte store is not cleared. Results cannot be held off by the receiver.
module byte_ring_queue_bulk_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  brq_pkg::t_req i_req,
    output logic          o_strobe,
    output brq_pkg::t_rsp o_rsp
);
    import brq_pkg::*;

    localparam int EXT_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam int FW    = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_run, n_run;
    logic             r_active, n_active;
    logic [LEN_W-1:0] r_left, n_left;
    logic [LEN_W-1:0] r_moved, n_moved;

    logic             r_strobe, n_strobe;
    logic             r_kind, n_kind;
    logic             r_valid, n_valid;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic [CNT_W-1:0] r_free, n_free;

    logic             accept;
    logic             ram_we;
    logic [7:0]       ram_q;
    logic [PTR_W-1:0] fill_now, fill_next, free_now, free_next;
    logic [LEN_W-1:0] cap_len, pop_n, cur_left, cur_moved;
    logic             issue;
    logic [FW-1:0]    free_ext;

    function automatic logic [PTR_W-1:0] fill_of(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
        logic [PTR_W:0] t;
        if (w >= r) begin
            t = {1'b0, w} - {1'b0, r};
        end else begin
            t = {1'b0, w} + (PTR_W+1)'(QUEUE_BYTES) - {1'b0, r};
        end
        return t[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_BYTES - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign busy   = r_active;
    assign accept = start && !r_active;

    assign fill_now = fill_of(r_wptr, r_rptr);
    assign free_now = PTR_W'(QUEUE_BYTES - 1) - fill_now;

    assign cap_len = (i_req.pop_length > LEN_W'(MAX_POP)) ? LEN_W'(MAX_POP)
                                                          : i_req.pop_length;
    assign pop_n   = (EXT_W'(cap_len) < EXT_W'(fill_now)) ? cap_len
                                                          : LEN_W'(fill_now);

    assign issue = r_active || (accept && i_req.req_type == REQ_POP && pop_n != '0);
    assign cur_left  = r_active ? r_left : pop_n;
    assign cur_moved = r_active ? r_moved : '0;

    assign ram_we = accept && i_req.req_type == REQ_PUSH && free_now != '0;

    always_comb begin
        n_rptr   = r_rptr;
        n_wptr   = r_wptr;
        n_run    = r_run;
        n_active = r_active;
        n_left   = r_left;
        n_moved  = r_moved;
        n_strobe = 1'b0;
        n_kind   = KIND_POP_RESULT;
        n_valid  = 1'b0;
        n_cnt    = '0;
        n_last   = 1'b1;

        if (issue) begin
            n_rptr   = ptr_inc(r_rptr);
            n_moved  = cur_moved + LEN_W'(1);
            n_left   = cur_left - LEN_W'(1);
            n_active = (cur_left != LEN_W'(1));
            n_strobe = 1'b1;
            n_kind   = KIND_POP_RESULT;
            n_valid  = 1'b1;
            n_cnt    = CNT_W'(n_moved);
            n_last   = (cur_left == LEN_W'(1));
        end else if (accept && i_req.req_type == REQ_POP) begin
            n_strobe = 1'b1;
        end else if (accept) begin
            if (ram_we) begin
                n_wptr = ptr_inc(r_wptr);
                if (r_run != CNT_W'(CNT_MAX)) begin
                    n_run = r_run + CNT_W'(1);
                end
            end
            if (i_req.push_run_end) begin
                n_strobe = 1'b1;
                n_kind   = KIND_PUSH_REPORT;
                n_cnt    = n_run;
                n_run    = '0;
            end
        end
    end

    assign fill_next = fill_of(n_wptr, n_rptr);
    assign free_next = PTR_W'(QUEUE_BYTES - 1) - fill_next;
    assign free_ext  = FW'(free_next);
    assign n_free    = free_ext[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr   <= '0;
            r_wptr   <= '0;
            r_run    <= '0;
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rptr   <= n_rptr;
            r_wptr   <= n_wptr;
            r_run    <= n_run;
            r_active <= n_active;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_moved <= n_moved;
        r_kind  <= n_kind;
        r_valid <= n_valid;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_free  <= n_free;
    end

    brq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (i_req.push_byte),
        .i_raddr (r_rptr),
        .o_rdata (ram_q)
    );

    assign o_strobe          = r_strobe;
    assign o_rsp.result_kind = r_kind;
    assign o_rsp.out_byte    = r_valid ? ram_q : 8'd0;
    assign o_rsp.byte_valid  = r_valid;
    assign o_rsp.moved_count = r_cnt;
    assign o_rsp.run_last    = r_last;
    assign o_rsp.free_bytes  = r_free;

endmodule
